>>> hw/rtl/vpo_pkg.sv
// Shared types, constants and arithmetic helpers of the vertex projection unit.
`timescale 1ns / 1ps
package vpo_pkg;

	typedef logic signed [31:0] q16_t;

	localparam logic FUNC_LOAD    = 1'b0;
	localparam logic FUNC_PROJECT = 1'b1;

	typedef enum logic [2:0] {
		REG_ORIGIN_X  = 3'd0,
		REG_ORIGIN_Y  = 3'd1,
		REG_SCALE_X   = 3'd2,
		REG_SCALE_Y   = 3'd3,
		REG_DEPTH_SEL = 3'd4
	} cfg_reg_t;

	localparam int CFG_IDX_W = 3;
	localparam int DEPTH_PRESETS = 7;
	localparam q16_t DEPTH_OFFSETS [8] = '{
		32'sd0, -32'sd98304, -32'sd196608, -32'sd294912,
		-32'sd393216, -32'sd491520, -32'sd589824, -32'sd688128
	};

	// 32767.0 in Q16.16.
	localparam logic [31:0] DEPTH_GAIN = 32'd2147418112;
	localparam q16_t Q16_MAX = 32'sh7FFF_FFFF;
	localparam q16_t Q16_MIN = 32'sh8000_0000;

	// Clip outcode pieces: six outside flags in the low bits, mirrored inside bits above.
	localparam int CODE_W = 28;
	localparam int CODE_FLAGS = 12;

	// Divider geometry: 64-bit dividend, 32-bit divisor, 33 quotient bits.
	localparam int DIV_NBITS = 64;
	localparam int DIV_DBITS = 32;
	localparam int DIV_QBITS = 33;

	typedef struct packed {
		logic             vis;
		logic             in_front;
		logic [CODE_W-1:0] code;
		logic             neg_x;
		logic             neg_y;
		logic             neg_z;
		logic             zero_z;
	} vpo_side_t;

	function automatic q16_t sat32(input logic signed [63:0] v);
		q16_t r;
		if (v > 64'sh0000_0000_7FFF_FFFF) begin
			r = Q16_MAX;
		end else if (v < -64'sh0000_0000_8000_0000) begin
			r = Q16_MIN;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	function automatic logic [63:0] abs64(input logic signed [63:0] v);
		logic [63:0] r;
		r = v[63] ? 64'(-v) : 64'(v);
		return r;
	endfunction

	function automatic logic [31:0] abs32(input q16_t v);
		logic [31:0] r;
		r = v[31] ? 32'(-v) : 32'(v);
		return r;
	endfunction

	// Signed quotient plus a base value, saturated to 32 bits.
	function automatic q16_t add_quo(input logic [DIV_QBITS-1:0] q, input logic neg,
			input q16_t base);
		logic signed [35:0] qs;
		logic signed [35:0] sum;
		qs = neg ? -$signed({3'b000, q}) : $signed({3'b000, q});
		sum = qs + 36'(base);
		return sat32({{28{sum[35]}}, sum});
	endfunction

endpackage

>>> hw/rtl/vpo_if.sv
// Handshake channel interfaces of the vertex projection unit.
`timescale 1ns / 1ps
interface vpo_item_if import vpo_pkg::*; ();
	logic  valid;
	logic  ready;
	logic  func;
	logic [3:0] entry_index;
	q16_t  entry_value;
	q16_t  point_x;
	q16_t  point_y;
	q16_t  point_z;
	modport source (output valid, func, entry_index, entry_value, point_x, point_y, point_z,
		input ready);
	modport sink (input valid, func, entry_index, entry_value, point_x, point_y, point_z,
		output ready);
endinterface

interface vpo_result_if import vpo_pkg::*; ();
	logic  valid;
	logic  ready;
	q16_t  screen_x;
	q16_t  screen_y;
	q16_t  screen_depth;
	logic [CODE_W-1:0] clip_code;
	logic  in_front;
	logic  visible;
	modport source (output valid, screen_x, screen_y, screen_depth, clip_code, in_front,
		visible, input ready);
	modport sink (input valid, screen_x, screen_y, screen_depth, clip_code, in_front,
		visible, output ready);
endinterface

interface vpo_cfg_if import vpo_pkg::*; ();
	logic  valid;
	logic  ready;
	logic [CFG_IDX_W-1:0] index;
	logic [31:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> hw/rtl/vpo_xform.sv
// Matrix storage and the two-stage row-vector transform p*M.
`timescale 1ns / 1ps
module vpo_xform import vpo_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  logic       take_point,
	input  logic       take_load,
	input  logic [3:0] load_index,
	input  q16_t       load_value,
	input  q16_t       px,
	input  q16_t       py,
	input  q16_t       pz,
	output logic       valid_s2,
	output q16_t       v_s2 [4]
);

	q16_t matrix_q [16];
	logic valid_s1;
	logic signed [63:0] prod_s1 [3][4];
	q16_t row3_s1 [4];
	q16_t pt [3];

	assign pt[0] = px;
	assign pt[1] = py;
	assign pt[2] = pz;

	always_ff @(posedge clk) begin
		if (take_load) begin
			matrix_q[load_index] <= load_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= take_point;
			valid_s2 <= valid_s1;
		end
	end

	// Stage 1: twelve exact products.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 4; j++) begin
					prod_s1[i][j] <= pt[i] * matrix_q[i*4+j];
				end
			end
			for (int j = 0; j < 4; j++) begin
				row3_s1[j] <= matrix_q[12+j];
			end
		end
	end

	// Stage 2: floor-shifted products summed with the origin row, then saturated.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 4; j++) begin
				v_s2[j] <= sat32(64'(row3_s1[j]) + (prod_s1[0][j] >>> 16)
					+ (prod_s1[1][j] >>> 16) + (prod_s1[2][j] >>> 16));
			end
		end
	end

endmodule

>>> hw/rtl/vpo_div.sv
// Pipelined restoring divider, one quotient bit per stage, with overflow detect.
`timescale 1ns / 1ps
module vpo_div import vpo_pkg::*; #(
	parameter int NBITS = DIV_NBITS,
	parameter int DBITS = DIV_DBITS,
	parameter int QBITS = DIV_QBITS
) (
	input  logic             clk,
	input  logic             en,
	input  logic [NBITS-1:0] num,
	input  logic [DBITS-1:0] den,
	output logic [QBITS-1:0] quo,
	output logic             ovf
);

	logic [DBITS-1:0] rem_s [QBITS];
	logic [QBITS-1:0] low_s [QBITS];
	logic [QBITS-1:0] quo_s [QBITS];
	logic [DBITS-1:0] den_s [QBITS];
	logic             ovf_s [QBITS];

	for (genvar k = 0; k < QBITS; k++) begin : g_stage
		logic [DBITS-1:0] rem_c;
		logic [QBITS-1:0] low_c;
		logic [QBITS-1:0] quo_c;
		logic [DBITS-1:0] den_c;
		logic             ovf_c;
		logic [DBITS:0]   trial;
		logic             ge;

		if (k == 0) begin : g_head
			assign rem_c = DBITS'(num[NBITS-1:QBITS]);
			assign low_c = num[QBITS-1:0];
			assign quo_c = '0;
			assign den_c = den;
			assign ovf_c = (DBITS'(num[NBITS-1:QBITS]) >= den);
		end else begin : g_link
			assign rem_c = rem_s[k-1];
			assign low_c = low_s[k-1];
			assign quo_c = quo_s[k-1];
			assign den_c = den_s[k-1];
			assign ovf_c = ovf_s[k-1];
		end

		assign trial = {rem_c, low_c[QBITS-1]};
		assign ge    = (trial >= {1'b0, den_c});

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? DBITS'(trial - {1'b0, den_c}) : DBITS'(trial);
				low_s[k] <= {low_c[QBITS-2:0], 1'b0};
				quo_s[k] <= {quo_c[QBITS-2:0], ge};
				den_s[k] <= den_c;
				ovf_s[k] <= ovf_c;
			end
		end
	end

	assign quo = quo_s[QBITS-1];
	assign ovf = ovf_s[QBITS-1];

endmodule

>>> hw/rtl/vertex_project_outcode_unit.sv
// Top level: transform, clip outcode and perspective divide of one vertex stream.
`timescale 1ns / 1ps
// A point item passes two transform stages, two outcode and numerator stages, 33 divider
// stages and one output register on its way to its result.
// Throughput: one item per cycle; the pipeline advances as one whole and stalls only while
// the output register holds a result that has not been taken.
// Load items write the matrix on acceptance and give no result.
// Reset clears all valid bits and the configuration registers; the matrix is undefined.
module vertex_project_outcode_unit import vpo_pkg::*; #(
	parameter int DEPTH_COUNT = DEPTH_PRESETS
) (
	input logic           clk,
	input logic           arst_n,
	vpo_item_if.sink      items,
	vpo_result_if.source  results,
	vpo_cfg_if.sink       cfg
);

	localparam int DLINE = DIV_QBITS;

	// Configuration registers.
	q16_t       origin_x_q;
	q16_t       origin_y_q;
	q16_t       scale_x_q;
	q16_t       scale_y_q;
	logic [2:0] depth_sel_q;
	q16_t       depth_off;

	// One enable moves every stage; it is low only when a result waits untaken.
	logic en;
	logic take_point;
	logic take_load;

	logic valid_s2;
	q16_t v_s2 [4];

	logic               valid_s3;
	logic [CODE_W-1:0]  code_s3;
	logic               vis_s3;
	logic               front_s3;
	logic signed [63:0] numx_s3;
	logic signed [63:0] numy_s3;
	logic signed [63:0] numz_s3;
	q16_t               w_s3;
	q16_t               z_s3;

	logic               valid_s4;
	vpo_side_t          side_s4;
	logic [63:0]        nx_s4;
	logic [63:0]        ny_s4;
	logic [63:0]        nz_s4;
	logic [31:0]        dw_s4;
	logic [31:0]        dz_s4;

	logic      valid_d [DLINE];
	vpo_side_t side_d  [DLINE];

	logic [DIV_QBITS-1:0] qx;
	logic [DIV_QBITS-1:0] qy;
	logic [DIV_QBITS-1:0] qz;
	logic                 ovfx;
	logic                 ovfy;
	logic                 ovfz;

	vpo_side_t side_f;
	q16_t      fx;
	q16_t      fy;
	q16_t      fz;
	logic [CODE_FLAGS-1:0] flags;

	assign en         = !results.valid || results.ready;
	assign items.ready = en;
	assign cfg.ready  = 1'b1;
	assign take_point = items.valid && en && (items.func == FUNC_PROJECT);
	assign take_load  = items.valid && en && (items.func == FUNC_LOAD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q  <= '0;
			origin_y_q  <= '0;
			scale_x_q   <= '0;
			scale_y_q   <= '0;
			depth_sel_q <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_ORIGIN_X:  origin_x_q  <= cfg.data;
				REG_ORIGIN_Y:  origin_y_q  <= cfg.data;
				REG_SCALE_X:   scale_x_q   <= cfg.data;
				REG_SCALE_Y:   scale_y_q   <= cfg.data;
				REG_DEPTH_SEL: depth_sel_q <= cfg.data[2:0];
				default: ;
			endcase
		end
	end

	// Presets beyond the configured count give a zero offset.
	assign depth_off = (int'(depth_sel_q) < DEPTH_COUNT) ? DEPTH_OFFSETS[depth_sel_q] : '0;

	vpo_xform u_xform (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.take_point (take_point),
		.take_load  (take_load),
		.load_index (items.entry_index),
		.load_value (items.entry_value),
		.px         (items.point_x),
		.py         (items.point_y),
		.pz         (items.point_z),
		.valid_s2   (valid_s2),
		.v_s2       (v_s2)
	);

	// Stage 3: plane tests against +/-W and the three numerator products.
	// Each outside flag has a mirrored inside bit, so the high field is the
	// complement of the low flags.
	always_comb begin
		logic signed [32:0] w_e;
		logic signed [32:0] lim;
		w_e = 33'(v_s2[3]);
		lim = -w_e;
		flags = '0;
		flags[1] = 33'(v_s2[0]) >= w_e;
		flags[0] = 33'(v_s2[0]) < lim;
		flags[2] = 33'(v_s2[1]) >= w_e;
		flags[3] = 33'(v_s2[1]) < lim;
		flags[4] = 33'(v_s2[2]) >= w_e;
		flags[5] = 33'(v_s2[2]) < lim;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			code_s3  <= {~flags, 4'b0000, flags};
			vis_s3   <= (flags == '0);
			front_s3 <= (v_s2[2] > 0);
			numx_s3  <= scale_x_q * v_s2[0];
			numy_s3  <= scale_y_q * v_s2[1];
			numz_s3  <= v_s2[3] * $signed({1'b0, DEPTH_GAIN});
			w_s3     <= v_s2[3];
			z_s3     <= v_s2[2];
		end
	end

	// Stage 4: magnitudes and quotient signs. A visible point has W > 0, so the
	// sign of each quotient follows its numerator and, for depth, Z.
	always_ff @(posedge clk) begin
		if (en) begin
			nx_s4 <= abs64(numx_s3);
			ny_s4 <= abs64(numy_s3);
			nz_s4 <= abs64(numz_s3);
			dw_s4 <= abs32(w_s3);
			dz_s4 <= abs32(z_s3);
			side_s4.vis      <= vis_s3;
			side_s4.in_front <= front_s3;
			side_s4.code     <= code_s3;
			side_s4.neg_x    <= numx_s3[63];
			side_s4.neg_y    <= numy_s3[63];
			side_s4.neg_z    <= numz_s3[63] ^ z_s3[31];
			side_s4.zero_z   <= (z_s3 == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			for (int k = 0; k < DLINE; k++) begin
				valid_d[k] <= 1'b0;
			end
		end else if (en) begin
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_d[0] <= valid_s4;
			for (int k = 1; k < DLINE; k++) begin
				valid_d[k] <= valid_d[k-1];
			end
		end
	end

	// Side information travels beside the divider stages.
	always_ff @(posedge clk) begin
		if (en) begin
			side_d[0] <= side_s4;
			for (int k = 1; k < DLINE; k++) begin
				side_d[k] <= side_d[k-1];
			end
		end
	end

	vpo_div u_div_x (.clk(clk), .en(en), .num(nx_s4), .den(dw_s4), .quo(qx), .ovf(ovfx));
	vpo_div u_div_y (.clk(clk), .en(en), .num(ny_s4), .den(dw_s4), .quo(qy), .ovf(ovfy));
	vpo_div u_div_z (.clk(clk), .en(en), .num(nz_s4), .den(dz_s4), .quo(qz), .ovf(ovfz));

	// Final stage: sign, base add and saturation. Screen x and y quotients never
	// exceed the scale in magnitude for a visible point, so their overflow flags
	// never fire there; for depth a huge quotient pins the result.
	assign side_f = side_d[DLINE-1];

	always_comb begin
		if (ovfx) begin
			fx = side_f.neg_x ? Q16_MIN : Q16_MAX;
		end else begin
			fx = add_quo(qx, side_f.neg_x, origin_x_q);
		end
		if (ovfy) begin
			fy = side_f.neg_y ? Q16_MIN : Q16_MAX;
		end else begin
			fy = add_quo(qy, side_f.neg_y, origin_y_q);
		end
		if (side_f.zero_z) begin
			fz = Q16_MAX;
		end else if (ovfz) begin
			fz = side_f.neg_z ? Q16_MIN : Q16_MAX;
		end else begin
			fz = add_quo(qz, side_f.neg_z, depth_off);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			results.valid <= 1'b0;
		end else if (en) begin
			results.valid <= valid_d[DLINE-1];
		end
	end

	// A hidden point reports zeros in the screen fields.
	always_ff @(posedge clk) begin
		if (en) begin
			results.screen_x     <= side_f.vis ? fx : '0;
			results.screen_y     <= side_f.vis ? fy : '0;
			results.screen_depth <= side_f.vis ? fz : '0;
			results.clip_code    <= side_f.code;
			results.in_front     <= side_f.in_front;
			results.visible      <= side_f.vis;
		end
	end

	a_hidden_zero: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && !results.visible |->
		results.screen_x == '0 && results.screen_y == '0 && results.screen_depth == '0)
		else $error("hidden point with nonzero screen fields");

	a_code_mirror: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid |-> results.clip_code[CODE_W-1:16] == ~results.clip_code[11:0])
		else $error("outcode inside bits do not mirror outside flags");

	a_visible_code: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid |-> results.visible == (results.clip_code[11:0] == '0))
		else $error("visible flag disagrees with outcode");

	a_stall_ready: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && !results.ready |-> !items.ready)
		else $error("input taken while the pipeline is stalled");

endmodule

>>> sim/vertex_project_outcode_unit_test.sv
// Self-checking testbench of the vertex projection unit with a cycle-free predictor.
`timescale 1ns / 1ps
module vertex_project_outcode_unit_test import vpo_pkg::*; ();

	// One pending input item, as the driver puts it on the channel.
	typedef struct {
		logic       func;
		logic [3:0] idx;
		q16_t       value;
		q16_t       px;
		q16_t       py;
		q16_t       pz;
	} vertex_item_t;

	// One projected point as the block should deliver it.
	typedef struct {
		q16_t              sx;
		q16_t              sy;
		q16_t              sd;
		logic [CODE_W-1:0] code;
		logic              front;
		logic              vis;
	} projection_t;

	logic clk;
	logic arst_n;

	vpo_item_if   items ();
	vpo_result_if results ();
	vpo_cfg_if    cfg ();

	vertex_project_outcode_unit u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (items),
		.results (results),
		.cfg     (cfg)
	);

	vertex_item_t pending_items [$];
	projection_t  expected_points [$];

	// Predictor state: our own copy of the matrix and the viewport registers.
	q16_t       mat [16];
	q16_t       org_x, org_y, scl_x, scl_y;
	logic [2:0] depth_sel;

	int errors = 0;
	int items_sent = 0;
	int points_checked = 0;
	int visible_seen = 0;
	bit quiet = 0;          // When set, neither side idles.
	bit item_taken = 0;     // Item accepted at the last rising edge.

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Saturates a wide signed value to Q16.16 range.
	function automatic q16_t clamp32(input longint v);
		if (v > 64'sd2147483647)
			return Q16_MAX;
		if (v < -64'sd2147483648)
			return Q16_MIN;
		return q16_t'(v);
	endfunction

	// Computes the projection of one point from the current matrix and viewport.
	function automatic projection_t project_point(input q16_t px, input q16_t py,
			input q16_t pz);
		projection_t r;
		q16_t   p [3];
		q16_t   v [4];
		longint acc, w, off, prod;
		logic [CODE_W-1:0] code;
		p[0] = px;
		p[1] = py;
		p[2] = pz;
		for (int j = 0; j < 4; j++) begin
			acc = longint'(mat[12 + j]);
			for (int i = 0; i < 3; i++) begin
				// Arithmetic shift of the exact product rounds toward minus infinity.
				prod = longint'(p[i]) * longint'(mat[i * 4 + j]);
				acc += prod >>> 16;
			end
			v[j] = clamp32(acc);
		end
		w = longint'(v[3]);
		code = 28'h0FFF0000;
		if (longint'(v[0]) >= w) code ^= 28'h0020002;
		if (longint'(v[0]) < -w) code ^= 28'h0010001;
		if (longint'(v[1]) >= w) code ^= 28'h0040004;
		if (longint'(v[1]) < -w) code ^= 28'h0080008;
		if (longint'(v[2]) >= w) code ^= 28'h0100010;
		if (longint'(v[2]) < -w) code ^= 28'h0200020;
		r.code = code;
		r.front = v[2] > 0;
		r.vis = code[CODE_FLAGS-1:0] == '0;
		r.sx = '0;
		r.sy = '0;
		r.sd = '0;
		if (r.vis && w > 0) begin
			r.sx = clamp32(longint'(org_x) + (longint'(scl_x) * longint'(v[0])) / w);
			r.sy = clamp32(longint'(org_y) + (longint'(scl_y) * longint'(v[1])) / w);
			off = (depth_sel < DEPTH_PRESETS) ? longint'(DEPTH_OFFSETS[depth_sel]) : 0;
			// A point on the eye plane gets the far depth limit.
			if (v[2] == 0)
				r.sd = Q16_MAX;
			else
				r.sd = clamp32(off + (w * 32767 * 65536) / longint'(v[2]));
		end
		return r;
	endfunction

	// Random value in [-lim, lim].
	function automatic q16_t rand_span(input int unsigned lim);
		return q16_t'($urandom_range(2 * lim)) - q16_t'(lim);
	endfunction

	// A matrix entry that keeps most points near the view volume.
	function automatic q16_t tame_entry(input int n);
		if (n == 15)
			return q16_t'($urandom_range(262144, 65536));
		if (n >= 12)
			return rand_span(32768);
		if ((n % 4) == 3)
			return rand_span(16384);
		return rand_span(131072);
	endfunction

	function automatic vertex_item_t load_item(input int n, input q16_t value);
		vertex_item_t it;
		it = '{func: FUNC_LOAD, idx: 4'(n), value: value, px: 32'($urandom),
			py: 32'($urandom), pz: 32'($urandom)};
		return it;
	endfunction

	function automatic vertex_item_t point_item(input q16_t x, input q16_t y, input q16_t z);
		vertex_item_t it;
		it = '{func: FUNC_PROJECT, idx: 4'($urandom), value: 32'($urandom),
			px: x, py: y, pz: z};
		return it;
	endfunction

	// Driver: presents pending items at the falling edge, idling about a quarter of cycles.
	always @(negedge clk) begin
		if (arst_n && (!items.valid || item_taken)) begin
			if (pending_items.size() > 0 && (quiet || $urandom_range(99) >= 24)) begin
				vertex_item_t it;
				it = pending_items.pop_front();
				items.func        <= it.func;
				items.entry_index <= it.idx;
				items.entry_value <= it.value;
				items.point_x     <= it.px;
				items.point_y     <= it.py;
				items.point_z     <= it.pz;
				items.valid       <= 1'b1;
			end else begin
				items.valid <= 1'b0;
			end
		end
		results.ready <= quiet || ($urandom_range(99) >= 24);
	end

	// Predictor and checker, both working on what the rising edge accepts.
	always @(posedge clk) begin
		item_taken = items.valid && items.ready;
		if (cfg.valid && cfg.ready) begin
			case (cfg_reg_t'(cfg.index))
				REG_ORIGIN_X:  org_x = cfg.data;
				REG_ORIGIN_Y:  org_y = cfg.data;
				REG_SCALE_X:   scl_x = cfg.data;
				REG_SCALE_Y:   scl_y = cfg.data;
				REG_DEPTH_SEL: depth_sel = cfg.data[2:0];
				default: ;
			endcase
		end
		if (item_taken) begin
			items_sent++;
			if (items.func == FUNC_LOAD)
				mat[items.entry_index] = items.entry_value;
			else
				expected_points.push_back(project_point(items.point_x, items.point_y,
					items.point_z));
		end
		if (results.valid && results.ready) begin
			if (expected_points.size() == 0) begin
				$display("%0t: result with nothing expected: x %h y %h code %h", $time,
					results.screen_x, results.screen_y, results.clip_code);
				errors++;
			end else begin
				projection_t e;
				e = expected_points.pop_front();
				points_checked++;
				if (e.vis)
					visible_seen++;
				if (results.screen_x !== e.sx) begin
					$display("%0t: screen_x expected %h actual %h", $time, e.sx,
						results.screen_x);
					errors++;
				end
				if (results.screen_y !== e.sy) begin
					$display("%0t: screen_y expected %h actual %h", $time, e.sy,
						results.screen_y);
					errors++;
				end
				if (results.screen_depth !== e.sd) begin
					$display("%0t: screen_depth expected %h actual %h", $time, e.sd,
						results.screen_depth);
					errors++;
				end
				if (results.clip_code !== e.code) begin
					$display("%0t: clip_code expected %h actual %h", $time, e.code,
						results.clip_code);
					errors++;
				end
				if (results.in_front !== e.front) begin
					$display("%0t: in_front expected %b actual %b", $time, e.front,
						results.in_front);
					errors++;
				end
				if (results.visible !== e.vis) begin
					$display("%0t: visible expected %b actual %b", $time, e.vis,
						results.visible);
					errors++;
				end
			end
		end
	end

	// Writes one viewport register; only called while the block is idle.
	task automatic write_reg(input cfg_reg_t idx, input logic [31:0] data);
		@(negedge clk);
		cfg.index <= idx;
		cfg.data  <= data;
		cfg.valid <= 1'b1;
		do @(posedge clk); while (!cfg.ready);
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	// Waits until every item is taken and every result has come, then lets the
	// pipeline run dry, since load items leave no trace in the result stream.
	task automatic wait_drained;
		wait (pending_items.size() == 0 && !items.valid);
		wait (expected_points.size() == 0);
		repeat (45) @(posedge clk);
	endtask

	task automatic load_matrix(input bit wild);
		for (int n = 0; n < 16; n++)
			pending_items.push_back(load_item(n, wild ? q16_t'($urandom) : tame_entry(n)));
	endtask

	initial begin
		q16_t lim;
		items.valid = 1'b0;
		items.func = FUNC_LOAD;
		items.entry_index = '0;
		items.entry_value = '0;
		items.point_x = '0;
		items.point_y = '0;
		items.point_z = '0;
		results.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		org_x = '0;
		org_y = '0;
		scl_x = '0;
		scl_y = '0;
		depth_sel = '0;
		foreach (mat[n])
			mat[n] = '0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part: identity matrix and unit viewport, then the corner cases.
		write_reg(REG_SCALE_X, 32'h0001_0000);
		write_reg(REG_SCALE_Y, 32'h0001_0000);
		for (int n = 0; n < 16; n++)
			pending_items.push_back(load_item(n, (n % 5 == 0) ? 32'sh0001_0000 : 32'sh0));
		// Center on the eye plane, two inner points, and points on and just outside the planes.
		pending_items.push_back(point_item(32'sh0, 32'sh0, 32'sh0));
		pending_items.push_back(point_item(32'sh8000, -32'sh8000, 32'sh4000));
		pending_items.push_back(point_item(32'sh0, 32'sh0, -32'sh4000));
		pending_items.push_back(point_item(32'sh0001_0000, 32'sh0, 32'sh1000));
		pending_items.push_back(point_item(-32'sh0001_0001, 32'sh0, 32'sh1000));
		pending_items.push_back(point_item(32'sh0, 32'sh0001_0000, 32'sh1000));
		pending_items.push_back(point_item(32'sh0, -32'sh0001_0001, 32'sh1000));
		pending_items.push_back(point_item(32'sh0, 32'sh0, 32'sh0001_0000));
		pending_items.push_back(point_item(32'sh0, 32'sh0, -32'sh0001_0001));
		pending_items.push_back(point_item(-32'sh0001_0000, 32'sh0, 32'sh1000));
		pending_items.push_back(point_item(Q16_MAX, Q16_MIN, Q16_MAX));
		pending_items.push_back(point_item(Q16_MIN, Q16_MAX, Q16_MIN));
		// Huge entries drive the transform into saturation.
		pending_items.push_back(load_item(0, Q16_MAX));
		pending_items.push_back(load_item(15, Q16_MIN));
		pending_items.push_back(point_item(Q16_MAX, 32'sh0, 32'sh0));
		pending_items.push_back(point_item(Q16_MIN, Q16_MIN, Q16_MIN));
		pending_items.push_back(load_item(15, Q16_MAX));
		pending_items.push_back(point_item(32'sh0, 32'sh0, 32'sh10));
		pending_items.push_back(point_item(32'sh0, 32'sh0, -32'sh10));
		wait_drained();

		// Random phases, each with its own viewport and matrix; the first two
		// take the register extremes, the others random values.
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: begin
					write_reg(REG_ORIGIN_X, Q16_MAX);
					write_reg(REG_ORIGIN_Y, Q16_MIN);
					write_reg(REG_SCALE_X, Q16_MAX);
					write_reg(REG_SCALE_Y, Q16_MIN);
				end
				1: begin
					write_reg(REG_ORIGIN_X, Q16_MIN);
					write_reg(REG_ORIGIN_Y, Q16_MAX);
					write_reg(REG_SCALE_X, Q16_MIN);
					write_reg(REG_SCALE_Y, Q16_MAX);
				end
				default: begin
					write_reg(REG_ORIGIN_X, $urandom);
					write_reg(REG_ORIGIN_Y, $urandom);
					write_reg(REG_SCALE_X, (ph % 2) ? $urandom : 32'(rand_span(32'h0100_0000)));
					write_reg(REG_SCALE_Y, (ph % 2) ? $urandom : 32'(rand_span(32'h0100_0000)));
				end
			endcase
			write_reg(REG_DEPTH_SEL, 32'(ph));
			// Phase four runs without any idling on either side.
			quiet = (ph == 4);
			load_matrix(ph == 6);
			for (int k = 0; k < 60; k++) begin
				int unsigned pick;
				pick = $urandom_range(99);
				lim = 32'sh0001_0000;
				if (pick < 85)
					pending_items.push_back(point_item(rand_span(lim), rand_span(lim),
						rand_span(lim)));
				else if (pick < 93)
					pending_items.push_back(point_item($urandom, $urandom, $urandom));
				else begin
					int n;
					n = $urandom_range(15);
					pending_items.push_back(load_item(n, ($urandom_range(3) == 0) ?
						q16_t'($urandom) : tame_entry(n)));
				end
			end
			wait_drained();
		end
		quiet = 0;

		$display("Ran %0d items, %0d projected points checked, %0d of them visible,",
			items_sent, points_checked, visible_seen);
		$display("across %0d viewport settings and every depth preset.", 9);
		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#20ms;
		$display("Timeout waiting for the block");
		$display("Some tests failed");
		$finish;
	end

endmodule

>>> filelist.f
hw/rtl/vpo_pkg.sv
hw/rtl/vpo_if.sv
hw/rtl/vpo_xform.sv
hw/rtl/vpo_div.sv
hw/rtl/vertex_project_outcode_unit.sv
sim/vertex_project_outcode_unit_test.sv
